FILE: hdl/r5sm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r5sm_pkg
// Shared types and constants for the RAID-5 stripe mapper.
// ----------------------------------------------------------------------------
package r5sm_pkg;

    localparam int LSEC_W  = 25;
    localparam int ROW_W   = 21;
    localparam int DISK_W  = 4;
    localparam int DCNT_W  = 5;
    localparam int SECS_W  = 22;
    localparam int STEP_W  = 5;

    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(LSEC_W);
    localparam logic [DCNT_W-1:0] NO_DISK   = 5'd16;
    localparam logic [ROW_W-1:0]  META_ROWS = 21'd1;

    typedef enum logic [1:0] {
        HEALTH_OK       = 2'd0,
        HEALTH_DEGRADED = 2'd1,
        HEALTH_FAILED   = 2'd2
    } health_t;

    typedef enum logic [1:0] {
        OP_MAP     = 2'd0,
        OP_ERROR   = 2'd1,
        OP_REBUILD = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAP,
        S_CHECK,
        S_DIV1,
        S_DIV2,
        S_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: hdl/r5sm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r5sm_div
// Bit-serial restoring divider, one quotient bit per cycle. Also tracks the
// quotient modulo a second small value (the modulus input) as the quotient bits come out.
// ----------------------------------------------------------------------------
module r5sm_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [r5sm_pkg::LSEC_W-1:0]       dividend,
    input  logic [r5sm_pkg::DISK_W-1:0]       divisor,
    input  logic [r5sm_pkg::DCNT_W-1:0]       modulus,
    output r5sm_pkg::div_stat_t               stat,
    output logic [r5sm_pkg::ROW_W-1:0]        quotient,
    output logic [r5sm_pkg::DISK_W-1:0]       remainder,
    output logic [r5sm_pkg::DISK_W-1:0]       quot_mod
);
    import r5sm_pkg::*;

    logic [LSEC_W-1:0] num_reg, num_next;
    logic [DISK_W-1:0] rem_reg, rem_next;
    logic [DISK_W-1:0] qm_reg, qm_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DISK_W:0]   trial;
    logic [DISK_W:0]   qtrial;
    logic              qbit;

    always_comb
    begin
        trial  = {rem_reg, num_reg[LSEC_W-1]};
        qbit   = (trial >= {1'b0, divisor});
        qtrial = {qm_reg, qbit};

        num_next  = num_reg;
        rem_next  = rem_reg;
        qm_next   = qm_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            qm_next   = '0;
            cnt_next  = DIV_STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[LSEC_W-2:0], qbit};
            rem_next = qbit ? DISK_W'(trial - {1'b0, divisor}) : trial[DISK_W-1:0];
            qm_next  = (qtrial >= modulus) ? DISK_W'(qtrial - modulus)
                                           : qtrial[DISK_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        qm_reg  <= qm_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg[ROW_W-1:0];
    assign remainder = rem_reg;
    assign quot_mod  = qm_reg;

endmodule

FILE: hdl/raid5_stripe_mapper_health.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raid5_stripe_mapper_health
// RAID-5 request mapper with rotating parity and array health tracking.
//
// Input channel (in_valid / in_stall) carries one item: map request, disk
// error report or rebuild complete. Output channel (out_valid / out_stall)
// returns exactly one result per item with the health after the item.
// Config channel (cfg_valid / cfg_ready) writes disk_count (index 0) and
// sectors_per_disk (index 1); always ready, write only while idle.
// Flow: an accepted map request runs the capacity check, then two 25-step
// passes of the shared bit-serial divider, one quotient bit per cycle; a
// refused request ends after the capacity check; error and rebuild items go straight to the result.
// One item is in work at a time; in_stall is high until the result is
// handed to the output register. The output register holds a result while
// out_stall is high, and the next item can be accepted meanwhile.
// Reset: health ok, no recorded disk, registers at 4 disks and 8192 sectors.
// ----------------------------------------------------------------------------
module raid5_stripe_mapper_health #(
    parameter int MAX_DISKS   = 16,
    parameter int MAX_SECTORS = 2097152
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      operation,
    input  logic [r5sm_pkg::LSEC_W-1:0]     logical_sector,
    input  logic [r5sm_pkg::LSEC_W-1:0]     sector_count,
    input  logic [r5sm_pkg::DISK_W-1:0]     error_disk,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            accepted,
    output logic [r5sm_pkg::ROW_W-1:0]      start_row,
    output logic [r5sm_pkg::DISK_W-1:0]     start_disk,
    output logic [r5sm_pkg::ROW_W-1:0]      end_row,
    output logic [r5sm_pkg::DISK_W-1:0]     end_disk,
    output logic [r5sm_pkg::ROW_W-1:0]      row_count,
    output logic [1:0]                      array_status,
    output logic [r5sm_pkg::DCNT_W-1:0]     failed_disk,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [r5sm_pkg::SECS_W-1:0]     cfg_data
);
    import r5sm_pkg::*;

    localparam logic [DCNT_W-1:0] DISKS_MAX = DCNT_W'(MAX_DISKS);
    localparam logic [SECS_W-1:0] SECS_MAX  = SECS_W'(MAX_SECTORS);

    state_t             state_reg, state_next;
    health_t            health_reg;
    logic [DCNT_W-1:0]  bad_disk_reg;
    logic [DCNT_W-1:0]  disk_count_reg;
    logic [SECS_W-1:0]  sectors_reg;

    logic [DCNT_W-1:0]  disks_reg;
    logic [DISK_W-1:0]  dd_reg;
    logic [ROW_W-1:0]   secm1_reg;
    logic [LSEC_W-1:0]  lsec_reg;
    logic [LSEC_W-1:0]  cnt_reg;
    logic [LSEC_W-1:0]  cap_reg;
    logic [LSEC_W:0]    sum_reg;

    logic               res_acc_reg;
    logic [ROW_W-1:0]   res_srow_reg, res_erow_reg, res_rows_reg;
    logic [DISK_W-1:0]  res_sdisk_reg, res_edisk_reg;

    logic               out_valid_reg;
    logic               out_acc_reg;
    logic [ROW_W-1:0]   out_srow_reg, out_erow_reg, out_rows_reg;
    logic [DISK_W-1:0]  out_sdisk_reg, out_edisk_reg;
    health_t            out_status_reg;
    logic [DCNT_W-1:0]  out_bad_reg;

    logic [DCNT_W-1:0]  eff_disks;
    logic [SECS_W-1:0]  eff_secs;
    logic               in_xfer;
    logic               out_free;
    logic               out_load;
    logic               req_ok;
    logic               div_start;
    logic [LSEC_W-1:0]  div_dividend;
    div_stat_t          div_stat;
    logic [ROW_W-1:0]   div_quot;
    logic [DISK_W-1:0]  div_rem;
    logic [DISK_W-1:0]  div_qmod;

    logic [ROW_W-1:0]   place_row;
    logic [DCNT_W-1:0]  rot_sum;
    logic [DISK_W-1:0]  rot;
    logic [DISK_W-1:0]  place_disk;

    always_comb
    begin
        eff_disks = disk_count_reg;
        if (eff_disks < DCNT_W'(2))
            eff_disks = DCNT_W'(2);
        if (eff_disks > DISKS_MAX)
            eff_disks = DISKS_MAX;
        eff_secs = sectors_reg;
        if (eff_secs < SECS_W'(2))
            eff_secs = SECS_W'(2);
        if (eff_secs > SECS_MAX)
            eff_secs = SECS_MAX;
    end

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign req_ok   = (health_reg != HEALTH_FAILED) && (cnt_reg != '0)
                      && (sum_reg <= {1'b0, cap_reg});
    assign cfg_ready = 1'b1;

    // placement of a divided sector: row, parity rotation, data disk
    always_comb
    begin
        place_row  = div_quot + META_ROWS;
        rot_sum    = {1'b0, div_qmod} + DCNT_W'(1);
        rot        = (rot_sum == disks_reg) ? '0 : rot_sum[DISK_W-1:0];
        place_disk = (div_rem >= rot) ? div_rem + DISK_W'(1) : div_rem;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = (operation == OP_MAP) ? S_CAP : S_FIN;
            end
            S_CAP:
                state_next = S_CHECK;
            S_CHECK:
                state_next = req_ok ? S_DIV1 : S_FIN;
            S_DIV1:
            begin
                if (div_stat.done)
                    state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_stat.done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall     = (state_reg != S_IDLE);
        div_start    = ((state_reg == S_CHECK) && req_ok)
                       || ((state_reg == S_DIV1) && div_stat.done);
        div_dividend = (state_reg == S_CHECK) ? lsec_reg
                                              : LSEC_W'(sum_reg - 1'b1);
        out_load     = (state_reg == S_FIN) && out_free;
    end

    r5sm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (dd_reg),
        .modulus   (disks_reg),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem),
        .quot_mod  (div_qmod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            health_reg     <= HEALTH_OK;
            bad_disk_reg   <= NO_DISK;
            disk_count_reg <= 5'd4;
            sectors_reg    <= 22'd8192;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index)
                    sectors_reg <= cfg_data;
                else
                    disk_count_reg <= cfg_data[DCNT_W-1:0];
            end
            if (in_xfer)
            begin
                case (operation)
                    OP_ERROR:
                    begin
                        if ({1'b0, error_disk} < eff_disks)
                        begin
                            if (health_reg == HEALTH_OK)
                            begin
                                health_reg   <= HEALTH_DEGRADED;
                                bad_disk_reg <= {1'b0, error_disk};
                            end
                            else if (health_reg == HEALTH_DEGRADED
                                     && bad_disk_reg != {1'b0, error_disk})
                                health_reg <= HEALTH_FAILED;
                        end
                    end
                    OP_REBUILD:
                    begin
                        if (health_reg == HEALTH_DEGRADED)
                        begin
                            health_reg   <= HEALTH_OK;
                            bad_disk_reg <= NO_DISK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            lsec_reg      <= logical_sector;
            cnt_reg       <= sector_count;
            disks_reg     <= eff_disks;
            dd_reg        <= DISK_W'(eff_disks - 1'b1);
            secm1_reg     <= ROW_W'(eff_secs - 1'b1);
            res_acc_reg   <= 1'b0;
            res_srow_reg  <= '0;
            res_sdisk_reg <= '0;
            res_erow_reg  <= '0;
            res_edisk_reg <= '0;
            res_rows_reg  <= '0;
        end
        if (state_reg == S_CAP)
        begin
            cap_reg <= LSEC_W'(dd_reg) * LSEC_W'(secm1_reg);
            sum_reg <= {1'b0, lsec_reg} + {1'b0, cnt_reg};
        end
        if ((state_reg == S_DIV1) && div_stat.done)
        begin
            res_srow_reg  <= place_row;
            res_sdisk_reg <= place_disk;
        end
        if ((state_reg == S_DIV2) && div_stat.done)
        begin
            res_acc_reg   <= 1'b1;
            res_erow_reg  <= place_row;
            res_edisk_reg <= place_disk;
            res_rows_reg  <= place_row - res_srow_reg + ROW_W'(1);
        end
        if (out_load)
        begin
            out_acc_reg    <= res_acc_reg;
            out_srow_reg   <= res_srow_reg;
            out_sdisk_reg  <= res_sdisk_reg;
            out_erow_reg   <= res_erow_reg;
            out_edisk_reg  <= res_edisk_reg;
            out_rows_reg   <= res_rows_reg;
            out_status_reg <= health_reg;
            out_bad_reg    <= bad_disk_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = out_acc_reg;
    assign start_row    = out_srow_reg;
    assign start_disk   = out_sdisk_reg;
    assign end_row      = out_erow_reg;
    assign end_disk     = out_edisk_reg;
    assign row_count    = out_rows_reg;
    assign array_status = out_status_reg;
    assign failed_disk  = out_bad_reg;

endmodule

FILE: hdl/r5sm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r5sm_checker
// Port-level checks for the RAID-5 stripe mapper, bound to the top level.
// ----------------------------------------------------------------------------
module r5sm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        accepted,
    input logic [20:0] start_row,
    input logic [20:0] end_row,
    input logic [20:0] row_count,
    input logic [1:0]  array_status
);
    import r5sm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    a_no_accept_failed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> array_status != HEALTH_FAILED)
        else $error("request accepted on failed array");

    a_row_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> row_count == 21'(end_row - start_row + 21'd1))
        else $error("row count mismatch");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> start_row == '0 && row_count == '0)
        else $error("refused result carries mapping");

endmodule

bind raid5_stripe_mapper_health r5sm_checker u_r5sm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .start_row    (start_row),
    .end_row      (end_row),
    .row_count    (row_count),
    .array_status (array_status)
);

FILE: sim/raid5_stripe_mapper_health_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raid5_stripe_mapper_health_tb
// Self-checking bench for the RAID-5 request mapper with health tracking.
//
// A behavioral predictor tracks array geometry and health and computes the
// mapping of every item sent. Directed items cover capacity edges, refused
// requests and every health transition; random items then run over a set of
// geometries, including saturated register values, with bursty input and a
// random output stall pattern. Each result is compared field by field.
// ----------------------------------------------------------------------------
module raid5_stripe_mapper_health_tb;

    import r5sm_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS  = 45;
    localparam int MAX_DISKS    = 16;
    localparam int MAX_SECTORS  = 2097152;
    localparam int PAD_W        = SECS_W - DCNT_W;

    localparam logic [1:0] OP_RESERVED    = 2'd3;
    localparam logic       REG_DISK_COUNT = 1'b0;
    localparam logic       REG_SECTORS    = 1'b1;

    typedef struct packed {
        logic [1:0]        op;
        logic [LSEC_W-1:0] lsec;
        logic [LSEC_W-1:0] count;
        logic [DISK_W-1:0] disk;
    } mapper_item_t;

    typedef struct packed {
        logic              accepted;
        logic [ROW_W-1:0]  start_row;
        logic [DISK_W-1:0] start_disk;
        logic [ROW_W-1:0]  end_row;
        logic [DISK_W-1:0] end_disk;
        logic [ROW_W-1:0]  row_count;
        health_t           status;
        logic [DCNT_W-1:0] failed_disk;
    } mapper_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] operation = '0;
    logic [LSEC_W-1:0] logical_sector = '0;
    logic [LSEC_W-1:0] sector_count = '0;
    logic [DISK_W-1:0] error_disk = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic accepted;
    logic [ROW_W-1:0] start_row;
    logic [DISK_W-1:0] start_disk;
    logic [ROW_W-1:0] end_row;
    logic [DISK_W-1:0] end_disk;
    logic [ROW_W-1:0] row_count;
    logic [1:0] array_status;
    logic [DCNT_W-1:0] failed_disk;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = REG_DISK_COUNT;
    logic [SECS_W-1:0] cfg_data = '0;

    // predictor state
    logic [DCNT_W-1:0] reg_disks = 5'd4;
    logic [SECS_W-1:0] reg_secs = 22'd8192;
    health_t health = HEALTH_OK;
    logic [DCNT_W-1:0] bad_disk = NO_DISK;

    mapper_result_t pending_results[$];
    mapper_result_t want_result;
    int items_sent = 0;
    int results_checked = 0;
    int mapped_requests = 0;
    int geometries = 1;
    int mismatches = 0;
    int cycles = 0;
    int burst_left = 10;
    int stall_mode = 0;
    int stall_span = 0;

    raid5_stripe_mapper_health i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .logical_sector (logical_sector),
        .sector_count   (sector_count),
        .error_disk     (error_disk),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .start_row      (start_row),
        .start_disk     (start_disk),
        .end_row        (end_row),
        .end_disk       (end_disk),
        .row_count      (row_count),
        .array_status   (array_status),
        .failed_disk    (failed_disk),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // output stall: random spans of no stall, light stall or heavy stall
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_span <= $urandom_range(20, 200);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 35);
            default: out_stall <= ($urandom_range(0, 99) < 85);
        endcase
    end

    function automatic longint unsigned eff_disks();
        if (reg_disks < 2)
            return 2;
        if (reg_disks > MAX_DISKS)
            return MAX_DISKS;
        return reg_disks;
    endfunction

    function automatic longint unsigned eff_secs();
        if (reg_secs < 2)
            return 2;
        if (reg_secs > MAX_SECTORS)
            return MAX_SECTORS;
        return reg_secs;
    endfunction

    function automatic longint unsigned capacity();
        return (eff_disks() - 1) * (eff_secs() - 1);
    endfunction

    // physical row and data disk of one logical sector, parity disk skipped
    function automatic void locate(input longint unsigned lsec, input longint unsigned disks,
                                   output longint unsigned row,
                                   output longint unsigned disk);
        longint unsigned slot;
        row  = lsec / (disks - 1) + META_ROWS;
        slot = lsec % (disks - 1);
        if (slot >= row % disks)
            slot++;
        disk = slot;
    endfunction

    function automatic mapper_result_t map_and_track(mapper_item_t it);
        mapper_result_t r;
        longint unsigned disks, first, srow, sdsk, erow, edsk;
        r     = '0;
        disks = eff_disks();
        first = it.lsec;
        case (it.op)
            OP_MAP:
            begin
                if (health != HEALTH_FAILED && it.count != 0 && first + it.count <= capacity())
                begin
                    locate(first, disks, srow, sdsk);
                    locate(first + it.count - 1, disks, erow, edsk);
                    r.accepted   = 1'b1;
                    r.start_row  = ROW_W'(srow);
                    r.start_disk = DISK_W'(sdsk);
                    r.end_row    = ROW_W'(erow);
                    r.end_disk   = DISK_W'(edsk);
                    r.row_count  = ROW_W'(erow - srow + 1);
                    mapped_requests++;
                end
            end
            OP_ERROR:
            begin
                if (it.disk < disks)
                begin
                    if (health == HEALTH_OK)
                    begin
                        health   = HEALTH_DEGRADED;
                        bad_disk = DCNT_W'(it.disk);
                    end
                    else if (health == HEALTH_DEGRADED && bad_disk != DCNT_W'(it.disk))
                    begin
                        health = HEALTH_FAILED;
                    end
                end
            end
            OP_REBUILD:
            begin
                if (health == HEALTH_DEGRADED)
                begin
                    health   = HEALTH_OK;
                    bad_disk = NO_DISK;
                end
            end
            default:
            begin
            end
        endcase
        r.status      = health;
        r.failed_disk = bad_disk;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no item outstanding");
                mismatches++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                check_field("accepted", want_result.accepted, accepted);
                check_field("start_row", want_result.start_row, start_row);
                check_field("start_disk", want_result.start_disk, start_disk);
                check_field("end_row", want_result.end_row, end_row);
                check_field("end_disk", want_result.end_disk, end_disk);
                check_field("row_count", want_result.row_count, row_count);
                check_field("array_status", want_result.status, array_status);
                check_field("failed_disk", want_result.failed_disk, failed_disk);
                results_checked++;
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [LSEC_W-1:0] lsec,
                             input logic [LSEC_W-1:0] cnt, input logic [DISK_W-1:0] idx);
        mapper_item_t it;
        it             = '{op, lsec, cnt, idx};
        in_valid       <= 1'b1;
        operation      <= op;
        logical_sector <= lsec;
        sector_count   <= cnt;
        error_disk     <= idx;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        pending_results.push_back(map_and_track(it));
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // both registers in one back-to-back write sequence; block is idle here
    task automatic set_geometry(input logic [DCNT_W-1:0] disks, input logic [SECS_W-1:0] secs);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= REG_DISK_COUNT;
        cfg_data  <= {PAD_W'($urandom), disks};
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        reg_disks = disks;
        cfg_index <= REG_SECTORS;
        cfg_data  <= secs;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        reg_secs = secs;
        cfg_valid <= 1'b0;
        geometries++;
    endtask

    task automatic random_request();
        longint unsigned room, lim, cnt, lsec;
        int kind;
        room = capacity();
        kind = $urandom_range(0, 99);
        if (kind < 50)
        begin
            lim  = (room < 40) ? room : 40;
            cnt  = $urandom_range(1, lim);
            lsec = $urandom_range(0, room - cnt);
        end
        else if (kind < 65)
        begin
            cnt  = $urandom_range(1, room);
            lsec = $urandom_range(0, room - cnt);
        end
        else if (kind < 72)
        begin
            lim  = (room < 100) ? room : 100;
            cnt  = $urandom_range(1, lim);
            lsec = room - cnt;
        end
        else if (kind < 80)
        begin
            lim  = (room < 100) ? room : 100;
            cnt  = $urandom_range(1, lim);
            lsec = room - cnt + $urandom_range(1, 50);
        end
        else if (kind < 85)
        begin
            cnt  = 0;
            lsec = $urandom_range(0, room);
        end
        else
        begin
            cnt  = $urandom;
            lsec = $urandom;
        end
        send_item(OP_MAP, LSEC_W'(lsec), LSEC_W'(cnt), DISK_W'($urandom));
    endtask

    // random mix; error reports never take the array to failed here
    task automatic random_item();
        int pick;
        logic [DISK_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            random_request();
        end
        else if (pick < 88)
        begin
            idx = DISK_W'($urandom);
            if (health == HEALTH_DEGRADED)
            begin
                if (eff_disks() < MAX_DISKS && $urandom_range(0, 1) == 1)
                    idx = DISK_W'($urandom_range(eff_disks(), MAX_DISKS - 1));
                else
                    idx = DISK_W'(bad_disk);
            end
            send_item(OP_ERROR, LSEC_W'($urandom), LSEC_W'($urandom), idx);
        end
        else if (pick < 96)
        begin
            send_item(OP_REBUILD, LSEC_W'($urandom), LSEC_W'($urandom), DISK_W'($urandom));
        end
        else
        begin
            send_item(OP_RESERVED, LSEC_W'($urandom), LSEC_W'($urandom), DISK_W'($urandom));
        end
    endtask

    task automatic test_reset_geometry();
        longint unsigned room;
        room = capacity();
        send_item(OP_MAP, '0, LSEC_W'(1), '0);
        send_item(OP_MAP, '0, '0, '0);
        send_item(OP_MAP, LSEC_W'(room - 5), LSEC_W'(5), '0);
        send_item(OP_MAP, LSEC_W'(room - 4), LSEC_W'(5), '0);
        send_item(OP_MAP, '0, LSEC_W'(room), '0);
        send_item(OP_MAP, '1, '1, '1);
        send_item(OP_RESERVED, '1, '1, '1);
    endtask

    task automatic test_health_tracking();
        send_item(OP_ERROR, '0, '0, 4'd9);
        send_item(OP_ERROR, '0, '0, 4'd2);
        send_item(OP_ERROR, '0, '0, 4'd2);
        send_item(OP_ERROR, '0, '0, 4'd12);
        send_item(OP_MAP, LSEC_W'(100), LSEC_W'(20), '0);
        send_item(OP_REBUILD, '0, '0, '0);
        send_item(OP_REBUILD, '0, '0, '0);
    endtask

    task automatic test_random_geometries();
        logic [DCNT_W-1:0] disk_set [9] = '{5'd4, 5'd2, 5'd16, 5'd3, 5'd0, 5'd31, 5'd1,
                                             5'd17, 5'd0};
        logic [SECS_W-1:0] sec_set [9] = '{22'd8192, 22'd2, 22'd2097152, 22'd2048, 22'd1,
                                            22'h3FFFFF, 22'd0, 22'd3, 22'd0};
        disk_set[8] = DCNT_W'($urandom);
        sec_set[8]  = SECS_W'($urandom);
        for (int p = 0; p < 9; p++)
        begin
            set_geometry(disk_set[p], sec_set[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
        end
    endtask

    task automatic test_array_failure();
        set_geometry(5'd4, 22'd8192);
        if (health == HEALTH_OK)
            send_item(OP_ERROR, '0, '0, 4'd1);
        send_item(OP_ERROR, '0, '0, (bad_disk == 0) ? 4'd1 : 4'd0);
        send_item(OP_MAP, '0, LSEC_W'(1), '0);
        send_item(OP_ERROR, '0, '0, 4'd2);
        send_item(OP_REBUILD, '0, '0, '0);
        send_item(OP_RESERVED, '0, '0, '0);
        for (int n = 0; n < 10; n++)
            random_item();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_geometry();
        test_health_tracking();
        test_random_geometries();
        test_array_failure();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d items (%0d requests mapped) over %0d geometries, %0d results checked.",
                 items_sent, mapped_requests, geometries, results_checked);
        $display("Covered capacity edges, saturated registers and all health transitions.");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
